@@ rtl/hex_color_line_parser_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the hex color line parser
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef HEX_COLOR_LINE_PARSER_UNIT_MACROS_SVH
`define HEX_COLOR_LINE_PARSER_UNIT_MACROS_SVH

// property holds at every edge
`define HCLP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define HCLP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hclp_pkg.sv @@
// ----------------------------------------------------------------------------
// hclp_pkg
// Types, character codes and hex decode helpers for the color line parser.
// ----------------------------------------------------------------------------
package hclp_pkg;

  localparam int unsigned LineLen       = 7;
  localparam int unsigned FillW         = 3;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;

  localparam logic [1:0] BEAT_FIRST = 2'd0;
  localparam logic [1:0] BEAT_TWO   = 2'd1;
  localparam logic [1:0] BEAT_THREE = 2'd2;
  localparam logic [1:0] BEAT_LAST  = 2'd3;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_ERASE,
    KIND_EOL
  } hclp_kind_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       upd;
    hclp_kind_e kind;
    logic [7:0] rx;
  } hclp_cmd_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] res;
    res = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      res = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      res = {1'b1, 4'(ch - 8'h57)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      res = {1'b1, 4'(ch - 8'h37)};
    end
    return res;
  endfunction

  function automatic logic [7:0] decode_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [4:0] h;
    logic [4:0] l;
    logic [7:0] res;
    h = hex_digit(hi);
    l = hex_digit(lo);
    if (!h[4]) begin
      res = 8'd0;
    end else if (!l[4]) begin
      res = {4'd0, h[3:0]};
    end else begin
      res = {h[3:0], l[3:0]};
    end
    return res;
  endfunction

endpackage

@@ rtl/hclp_front.sv @@
// ----------------------------------------------------------------------------
// hclp_front
// Classifies each received byte, edits the line buffer, loads color levels.
// ----------------------------------------------------------------------------
module hclp_front import hclp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       q_full_i,
  output logic       in_ready_o,
  output logic       push_o,
  output hclp_cmd_t  push_cmd_o
);

  logic [7:0]       line_q [LineLen];
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic             accept;
  logic             upd;
  logic             store_we;
  hclp_kind_e       kind;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    if (in_byte_i == CH_BS || in_byte_i == CH_DEL) begin
      kind = KIND_ERASE;
    end else if (in_byte_i == CH_LF || in_byte_i == CH_CR) begin
      kind = KIND_EOL;
    end else begin
      kind = KIND_CHAR;
    end
  end

  always_comb begin
    fill_d   = fill_q;
    red_d    = red_q;
    green_d  = green_q;
    blue_d   = blue_q;
    upd      = 1'b0;
    store_we = 1'b0;
    if (accept) begin
      case (kind)
        KIND_ERASE: begin
          if (fill_q != '0) fill_d = fill_q - 1'b1;
        end
        KIND_EOL: begin
          fill_d = '0;
          if (fill_q == FillW'(LineLen) && line_q[0] == CH_HASH) begin
            upd     = 1'b1;
            red_d   = decode_pair(line_q[1], line_q[2]);
            green_d = decode_pair(line_q[3], line_q[4]);
            blue_d  = decode_pair(line_q[5], line_q[6]);
          end
        end
        KIND_CHAR: begin
          if (fill_q < FillW'(LineLen)) begin
            store_we = 1'b1;
            fill_d   = fill_q + 1'b1;
          end
        end
        default: begin
          fill_d = fill_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
    end else begin
      fill_q  <= fill_d;
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) line_q[fill_q] <= in_byte_i;
  end

  assign push_o = accept;
  always_comb begin
    push_cmd_o.rx    = in_byte_i;
    push_cmd_o.kind  = kind;
    push_cmd_o.upd   = upd;
    push_cmd_o.red   = red_d;
    push_cmd_o.green = green_d;
    push_cmd_o.blue  = blue_d;
  end

endmodule

@@ rtl/hclp_queue.sv @@
// ----------------------------------------------------------------------------
// hclp_queue
// Small command queue between the front and back sections.
// ----------------------------------------------------------------------------
module hclp_queue import hclp_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  hclp_cmd_t push_cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output hclp_cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hclp_cmd_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = cnt_q == CntW'(Depth);
  assign valid_o   = cnt_q != '0;
  assign do_wr     = push_i && !full_o;
  assign do_rd     = pop_i && valid_o;
  assign pop_cmd_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_wr) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    if (do_rd) rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_q] <= push_cmd_i;
  end

endmodule

@@ rtl/hclp_back.sv @@
// ----------------------------------------------------------------------------
// hclp_back
// Echo sequencer: plays out one or four echo items per command.
// ----------------------------------------------------------------------------
module hclp_back import hclp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  hclp_cmd_t  q_cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_upd_o,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o
);

  hclp_cmd_t  cur_q, cur_d;
  logic       busy_q, busy_d;
  logic [1:0] beat_q, beat_d;
  logic       fire, last_beat, take;

  assign last_beat = (cur_q.kind == KIND_CHAR) ? (beat_q == BEAT_FIRST)
                                               : (beat_q == BEAT_LAST);
  assign fire = busy_q && out_ready_i;
  assign take = !busy_q || (fire && last_beat);
  assign pop_o = take && q_valid_i;

  always_comb begin
    busy_d = busy_q;
    beat_d = beat_q;
    cur_d  = cur_q;
    if (take) begin
      busy_d = q_valid_i;
      beat_d = BEAT_FIRST;
      cur_d  = q_cmd_i;
    end else if (fire) begin
      beat_d = beat_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= BEAT_FIRST;
    end else begin
      busy_q <= busy_d;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_comb begin
    case (beat_q)
      BEAT_FIRST: out_byte_o = cur_q.rx;
      BEAT_TWO:   out_byte_o = (cur_q.kind == KIND_EOL) ? CH_CR : CH_BS;
      BEAT_THREE: out_byte_o = (cur_q.kind == KIND_EOL) ? CH_LF : CH_SPACE;
      BEAT_LAST:  out_byte_o = (cur_q.kind == KIND_EOL) ? CH_TAB : CH_BS;
      default:    out_byte_o = cur_q.rx;
    endcase
  end

  assign out_valid_o = busy_q;
  assign out_last_o  = last_beat;
  assign out_upd_o   = last_beat && cur_q.upd;
  assign out_red_o   = cur_q.red;
  assign out_green_o = cur_q.green;
  assign out_blue_o  = cur_q.blue;

endmodule

@@ rtl/hex_color_line_parser_unit.sv @@
// ----------------------------------------------------------------------------
// hex_color_line_parser_unit
// Serial line editor with echo that sets RGB levels from a "#rrggbb" line.
// ----------------------------------------------------------------------------
// Every received byte is echoed; backspace/DEL adds "\b \b" and CR/LF adds
// "\r\n\t", so a byte yields one or four output items. The output side moves
// one item per cycle while m_axis_tready is high, paced by the echo sequencer
// in the back section. The front takes a byte every cycle while the command
// queue (QueueDepth entries) has room.
// Red, green and blue on each item are the levels in effect after its byte;
// tuser flags the final item of a line end that loaded new levels.
module hex_color_line_parser_unit import hclp_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] tx_byte, [15:8] red, [23:16] green, [31:24] blue
  output logic        m_axis_tlast,   // last
  output logic        m_axis_tuser    // [0] color_update
);

  hclp_cmd_t  push_cmd, pop_cmd;
  logic       push, pop, q_full, q_valid;
  logic [7:0] tx_byte, red, green, blue;

  hclp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  hclp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  hclp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (tx_byte),
    .out_last_o  (m_axis_tlast),
    .out_upd_o   (m_axis_tuser),
    .out_red_o   (red),
    .out_green_o (green),
    .out_blue_o  (blue)
  );

  assign m_axis_tdata = {blue, green, red, tx_byte};

endmodule

@@ rtl/hclp_checker.sv @@
// ----------------------------------------------------------------------------
// hclp_checker
// Port-level checks for the color line parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "hex_color_line_parser_unit_macros.svh"

module hclp_checker import hclp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  `HCLP_ASSERT(a_upd_on_last, !(m_axis_tvalid && m_axis_tuser) || m_axis_tlast, "update not on last")
  `HCLP_ASSERT(a_upd_after_tab, !(m_axis_tvalid && m_axis_tuser) || (m_axis_tdata[7:0] == CH_TAB), "update not on line end echo")
  `HCLP_ASSERT_NEXT(a_run_levels, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[31:8] == $past(m_axis_tdata[31:8])), "levels changed inside a run")
  `HCLP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output changed")
  // byte passes the queue, then the echo sequencer's registers, before its echo shows up
  `HCLP_ASSERT_NEXT(a_in_echo, in_fire && !m_axis_tvalid, ##1 m_axis_tvalid, "accepted byte not echoed")

endmodule

bind hex_color_line_parser_unit hclp_checker u_hclp_checker (.*);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks hex_color_line_parser_unit: each accepted byte runs through an
// in-bench line editor model that queues the echo items it should cause.
// A short table of directed bytes comes first, then random "#rrggbb" lines,
// broken lines and noise, under several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module testbench;
  import hclp_pkg::*;

  localparam int StallLimit = 2000;
  localparam int PhaseBytes = 34;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
    logic       upd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } echo_item_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic [7:0] tx;
    logic       upd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } dir_row_t;

  // typed rows give the final item of that byte
  localparam dir_row_t DirTab [0:22] = '{
    '{8'h41, 1'b1, 8'h41, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h08, 1'b1, 8'h08, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h08, 1'b1, 8'h08, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h7F, 1'b1, 8'h08, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h23, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h46, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h46, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h30, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h30, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h61, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h35, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h0D, 1'b1, 8'h09, 1'b1, 8'hFF, 8'h00, 8'hA5},
    '{8'h23, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h37, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h7A, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h47, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h31, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h62, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h43, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b1, 8'hFF, 1'b0, 8'hFF, 8'h00, 8'hA5},
    '{8'h0A, 1'b1, 8'h09, 1'b1, 8'h07, 8'h00, 8'hBC},
    '{8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{8'h0D, 1'b1, 8'h09, 1'b0, 8'h07, 8'h00, 8'hBC}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  hex_color_line_parser_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // line editor model state
  logic [7:0] line_buf [LineLen];
  logic [2:0] line_fill = 3'd0;
  logic [7:0] lvl_red   = 8'h00;
  logic [7:0] lvl_green = 8'h00;
  logic [7:0] lvl_blue  = 8'h00;

  echo_item_t echo_expect_q [$];
  dir_row_t   typed_q [$];
  logic [7:0] byte_q [$];

  int send_idle;
  int recv_stall;
  int mismatches   = 0;
  int stall_cycles = 0;

  function automatic int hex_nibble(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch - "0");
    if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
    if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] pair_level(input logic [7:0] hi, input logic [7:0] lo);
    int h;
    int l;
    h = hex_nibble(hi);
    l = hex_nibble(lo);
    if (h < 0) return 8'h00;
    if (l < 0) return 8'(h);
    return 8'(h * 16 + l);
  endfunction

  task automatic predict_echo(input logic [7:0] c);
    logic [7:0] seq [4];
    int         n_out;
    logic       loaded;
    echo_item_t it;
    seq[0] = c;
    n_out  = 1;
    loaded = 1'b0;
    if (c == CH_BS || c == CH_DEL) begin
      seq[1] = CH_BS;
      seq[2] = CH_SPACE;
      seq[3] = CH_BS;
      n_out  = 4;
      if (line_fill != 3'd0) line_fill = line_fill - 3'd1;
    end else if (c == CH_LF || c == CH_CR) begin
      seq[1] = CH_CR;
      seq[2] = CH_LF;
      seq[3] = CH_TAB;
      n_out  = 4;
      if (line_fill == LineLen && line_buf[0] == CH_HASH) begin
        lvl_red   = pair_level(line_buf[1], line_buf[2]);
        lvl_green = pair_level(line_buf[3], line_buf[4]);
        lvl_blue  = pair_level(line_buf[5], line_buf[6]);
        loaded    = 1'b1;
      end
      line_fill = 3'd0;
    end else if (line_fill < LineLen) begin
      line_buf[line_fill] = c;
      line_fill = line_fill + 3'd1;
    end
    for (int k = 0; k < n_out; k++) begin
      it.tx    = seq[k];
      it.last  = (k == n_out - 1);
      it.upd   = loaded && (k == n_out - 1);
      it.red   = lvl_red;
      it.green = lvl_green;
      it.blue  = lvl_blue;
      echo_expect_q.push_back(it);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin : monitor
    echo_item_t exp_it;
    echo_item_t got_it;
    dir_row_t   row;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_echo(s_axis_tdata);
      if (typed_q.size() != 0) begin
        row = typed_q.pop_front();
        if (row.typed) begin
          exp_it       = echo_expect_q.pop_back();
          exp_it.tx    = row.tx;
          exp_it.upd   = row.upd;
          exp_it.red   = row.red;
          exp_it.green = row.green;
          exp_it.blue  = row.blue;
          echo_expect_q.push_back(exp_it);
        end
      end
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_it = '{m_axis_tdata[7:0], m_axis_tlast, m_axis_tuser,
                 m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tdata[31:24]};
      if (echo_expect_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: tx=%h last=%b upd=%b rgb=%h %h %h",
                   got_it.tx, got_it.last, got_it.upd, got_it.red, got_it.green, got_it.blue);
        mismatches++;
      end else begin
        exp_it = echo_expect_q.pop_front();
        if (got_it.tx !== exp_it.tx || got_it.last !== exp_it.last ||
            got_it.upd !== exp_it.upd || got_it.red !== exp_it.red ||
            got_it.green !== exp_it.green || got_it.blue !== exp_it.blue) begin
          if (mismatches < 10)
            $display("mismatch: exp tx=%h last=%b upd=%b rgb=%h %h %h, got tx=%h last=%b upd=%b rgb=%h %h %h",
                     exp_it.tx, exp_it.last, exp_it.upd, exp_it.red, exp_it.green, exp_it.blue,
                     got_it.tx, got_it.last, got_it.upd, got_it.red, got_it.green, got_it.blue);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("[hex_color_line_parser_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (echo_expect_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_hex();
    string hx;
    hx = "0123456789abcdefABCDEF";
    return hx[$urandom_range(21)];
  endfunction

  // mostly well-formed "#rrggbb" lines, some broken lines, some raw noise
  task automatic build_line();
    int         kind;
    int         len;
    int         typo_at;
    logic [7:0] eol;
    kind    = $urandom_range(99);
    eol     = $urandom_range(1) ? CH_CR : CH_LF;
    typo_at = ($urandom_range(99) < 15) ? $urandom_range(6, 1) : 0;
    if (kind < 60) begin
      byte_q.push_back(CH_HASH);
      for (int k = 1; k < LineLen; k++) begin
        if (k == typo_at) begin
          byte_q.push_back(8'($urandom_range(255)));
          byte_q.push_back($urandom_range(1) ? CH_BS : CH_DEL);
        end
        byte_q.push_back(($urandom_range(99) < 85) ? pick_hex() : 8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 10) begin
        len = $urandom_range(3, 1);
        for (int k = 0; k < len; k++) byte_q.push_back(8'($urandom_range(255)));
      end
      byte_q.push_back(eol);
    end else if (kind < 80) begin
      len = $urandom_range(8);
      byte_q.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : CH_HASH);
      for (int k = 0; k < len; k++)
        byte_q.push_back(($urandom_range(1) == 0) ? pick_hex() : 8'($urandom_range(255)));
      byte_q.push_back(eol);
    end else begin
      len = $urandom_range(6, 1);
      for (int k = 0; k < len; k++) byte_q.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int phase_sent;
    bit held;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    m_axis_tready = 1'b0;
    rst_ni        = 1'b0;
    send_idle     = 0;
    recv_stall    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(DirTab); i++) begin
      typed_q.push_back(DirTab[i]);
      send_byte(DirTab[i].rx);
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 88; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 88; end
        default: begin send_idle = 27; recv_stall = 27; end
      endcase
      phase_sent = 0;
      held       = 1'b0;
      while (phase_sent < PhaseBytes) begin
        build_line();
        phase_sent += byte_q.size();
        while (byte_q.size() != 0) send_byte(byte_q.pop_front());
        if (!held && phase_sent >= PhaseBytes / 2) begin
          wait_drained();
          held = 1'b1;
        end
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && echo_expect_q.size() == 0) begin
      $display("[hex_color_line_parser_unit] OK");
    end else begin
      $display("[hex_color_line_parser_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ hex_color_line_parser_unit.f @@
+incdir+rtl
rtl/hclp_pkg.sv
rtl/hclp_front.sv
rtl/hclp_queue.sv
rtl/hclp_back.sv
rtl/hex_color_line_parser_unit.sv
rtl/hclp_checker.sv
tb/testbench.sv
